### rtl/wrtbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrtbm_pkg
// Shared types, constants and helpers for the wildcard rule table.
// ----------------------------------------------------------------------------
package wrtbm_pkg;

	localparam int MAX_ENTRIES_D = 32;
	localparam int KIND_COUNT    = 6;
	localparam int ACTION_COUNT  = 16;
	localparam int ID_FIELDS     = 6;

	localparam logic [31:0] WILD_ID = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_CLR  = 2'd0,
		OP_REG  = 2'd1,
		OP_FIND = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INV     = 2'd1,
		ST_FULL    = 2'd2,
		ST_NOMATCH = 2'd3
	} status_t;

	// ids[0] definition .. ids[5] component
	typedef struct packed {
		logic [2:0]                     kind;
		logic [7:0]                     action;
		logic [ID_FIELDS-1:0][31:0]     ids;
	} rule_key_t;

	// transaction token walking down the cell row
	typedef struct packed {
		logic        valid;
		op_t         op;
		logic        kv;
		logic        done;
		logic        append;
		logic        have;
		logic [5:0]  spec;
		logic [31:0] fh;
		logic [31:0] fc;
		rule_key_t   key;
	} tok_t;

	function automatic logic [5:0] spec_of(input rule_key_t k);
		logic [5:0] s;
		s = '0;
		for (int j = 0; j < ID_FIELDS; j++) begin
			s[ID_FIELDS-1-j] = (k.ids[j] != WILD_ID);
		end
		return s;
	endfunction

	function automatic logic key_ok(input rule_key_t k);
		logic ok;
		ok = (k.kind >= 3'd1) && (k.kind <= 3'(KIND_COUNT)) &&
			(k.action >= 8'd1) && (k.action <= 8'(ACTION_COUNT));
		for (int j = 0; j < ID_FIELDS; j++) begin
			ok = ok && (!k.ids[j][31] || k.ids[j] == WILD_ID);
		end
		return ok;
	endfunction

endpackage
`default_nettype wire

### rtl/wildcard_rule_table_best_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_rule_table_best_match
// Wildcard rule table with most-specific-match lookup on a row of rule cells.
// ----------------------------------------------------------------------------
// A transaction's token passes the register of every cell and then the output
//   register before m_axis_tvalid; it walks the cell row one cell a cycle
//   unless the output stalls, and the next is taken once it has left the row.
// Reset: rule count cleared at once; rule slots stay undefined until written,
//   no clearing pass.
module wildcard_rule_table_best_match
	import wrtbm_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_D
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// kind, action, definition_key, group_key, item_key, spell_key,
	// panel_key, component_key, handler_ref, handler_context, zero pad
	input  wire logic [271:0] s_axis_tdata,
	// operation
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// status, entry_index, found_handler, found_context,
	// match_specificity, entries_used, zero pad
	output logic [87:0]       m_axis_tdata
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic          busy_q;
	logic [CW-1:0] count_q;
	logic          out_vld_q;
	logic [87:0]   out_q;

	tok_t          tok_c [0:MAX_ENTRIES];
	logic [IW-1:0] idx_c [0:MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] vld_vec;

	tok_t          inj;
	tok_t          tail;
	logic          accept;
	logic          adv;
	logic          load;

	assign s_axis_tready = !busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		inj.valid  = accept;
		inj.op     = op_t'(s_axis_tuser);
		inj.done   = 1'b0;
		inj.append = 1'b0;
		inj.have   = 1'b0;
		inj.spec   = '0;
		inj.key.kind   = s_axis_tdata[2:0];
		inj.key.action = s_axis_tdata[10:3];
		for (int j = 0; j < ID_FIELDS; j++) begin
			inj.key.ids[j] = s_axis_tdata[11 + 32*j +: 32];
		end
		inj.fh = s_axis_tdata[234:203];
		inj.fc = s_axis_tdata[266:235];
		inj.kv = key_ok(inj.key) && (inj.op != OP_REG || inj.fh != 32'd0);
	end

	assign tok_c[0] = inj;
	assign idx_c[0] = '0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		wrtbm_cell #(
			.MAX_ENTRIES(MAX_ENTRIES),
			.IDX        (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.count  (count_q),
			.tok_in (tok_c[i]),
			.idx_in (idx_c[i]),
			.tok_out(tok_c[i+1]),
			.idx_out(idx_c[i+1])
		);
		assign vld_vec[i] = tok_c[i+1].valid;
	end

	assign tail = tok_c[MAX_ENTRIES];
	assign adv  = !(tail.valid && out_vld_q && !m_axis_tready);
	assign load = tail.valid && adv;

	status_t       r_st;
	logic [IW-1:0] r_idx;
	logic [31:0]   r_fh;
	logic [31:0]   r_fc;
	logic [5:0]    r_spec;
	logic [CW-1:0] r_cnt;

	always_comb begin
		r_st   = ST_INV;
		r_idx  = '0;
		r_fh   = '0;
		r_fc   = '0;
		r_spec = '0;
		r_cnt  = count_q;
		case (tail.op)
			OP_CLR: begin
				r_st  = ST_OK;
				r_cnt = '0;
			end
			OP_REG: begin
				if (tail.kv) begin
					if (tail.done) begin
						r_st  = ST_OK;
						r_idx = idx_c[MAX_ENTRIES];
						if (tail.append) begin
							r_cnt = count_q + CW'(1);
						end
					end else begin
						r_st = ST_FULL;
					end
				end
			end
			OP_FIND: begin
				if (tail.kv) begin
					if (tail.have) begin
						r_st   = ST_OK;
						r_idx  = idx_c[MAX_ENTRIES];
						r_fh   = tail.fh;
						r_fc   = tail.fc;
						r_spec = tail.spec;
					end else begin
						r_st = ST_NOMATCH;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			count_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				count_q   <= r_cnt;
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= {5'd0, 6'(r_cnt), r_spec, r_fc, r_fh, 5'(r_idx), r_st};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(vld_vec))
		else $error("more than one token in the cell row");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !tail.valid)
		else $error("token at row end while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && !s_axis_tready)
		else $error("accepted transaction did not set busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("rule count beyond table depth");

endmodule
`default_nettype wire

### rtl/wrtbm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrtbm_cell
// One rule slot. Holds a key and handler, updates the passing token.
// ----------------------------------------------------------------------------
module wrtbm_cell
	import wrtbm_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_D,
	parameter int IDX         = 0,
	localparam int CW = $clog2(MAX_ENTRIES + 1),
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic [CW-1:0] count,
	input  wire tok_t          tok_in,
	input  wire logic [IW-1:0] idx_in,
	output tok_t               tok_out,
	output logic [IW-1:0]      idx_out
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);
	localparam logic [IW-1:0] IDX_I = IW'(IDX);

	rule_key_t   key_q;
	logic [5:0]  spec_q;
	logic [31:0] hnd_q;
	logic [31:0] ctx_q;
	tok_t        tok_q;
	logic        vld_q;
	logic [IW-1:0] idx_q;

	tok_t          nxt;
	logic [IW-1:0] nidx;
	logic          wr_hnd;
	logic          wr_key;
	logic          used;
	logic          eq;
	logic          hit;

	always_comb begin
		used = (IDX_C < count);
		eq   = used && (key_q == tok_in.key);
		hit  = used && (key_q.kind == tok_in.key.kind) &&
			(key_q.action == tok_in.key.action);
		for (int j = 0; j < ID_FIELDS; j++) begin
			hit = hit && (key_q.ids[j] == WILD_ID || key_q.ids[j] == tok_in.key.ids[j]);
		end
	end

	always_comb begin
		nxt    = tok_in;
		nidx   = idx_in;
		wr_hnd = 1'b0;
		wr_key = 1'b0;
		if (tok_in.valid && tok_in.kv) begin
			case (tok_in.op)
				OP_REG: begin
					if (!tok_in.done) begin
						if (eq) begin
							nxt.done = 1'b1;
							nidx     = IDX_I;
							wr_hnd   = 1'b1;
						end else if (IDX_C == count) begin
							nxt.done   = 1'b1;
							nxt.append = 1'b1;
							nidx       = IDX_I;
							wr_hnd     = 1'b1;
							wr_key     = 1'b1;
						end
					end
				end
				OP_FIND: begin
					if (hit && (!tok_in.have || spec_q > tok_in.spec)) begin
						nxt.have = 1'b1;
						nxt.spec = spec_q;
						nxt.fh   = hnd_q;
						nxt.fc   = ctx_q;
						nidx     = IDX_I;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= nxt;
			idx_q <= nidx;
			if (wr_hnd) begin
				hnd_q <= tok_in.fh;
				ctx_q <= tok_in.fc;
			end
			if (wr_key) begin
				key_q  <= tok_in.key;
				spec_q <= spec_of(tok_in.key);
			end
		end
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = vld_q;
	end

	assign idx_out = idx_q;

endmodule
`default_nettype wire
